[hw/rtl/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/wbts_pkg.sv]
// shared constants, types and helpers of the texture sampler
package wbts_pkg;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned AddrBits  = 16;
  localparam int unsigned SideBits  = 11;
  localparam int unsigned MaxSide   = 1024;
  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegFilter = 2'd2,
    RegSpare  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KindWrite  = 1'b0,
    KindSample = 1'b1
  } kind_e;

  typedef logic [23:0] texel_t;

  // per-stage control carried alongside the data
  typedef struct packed {
    logic valid;
    logic white;
    logic bilinear;
  } stage_ctl_t;

  // clamp a side to the largest supported size
  function automatic logic [SideBits-1:0] side_of(input logic [SideBits-1:0] v);
    side_of = (v > SideBits'(MaxSide)) ? SideBits'(MaxSide) : v;
  endfunction
endpackage

[hw/rtl/wrapped_bilinear_texture_sampler.sv]
// top level: configuration, texel banks, address and blend pipelines
// an accepted sample word passes the address, bank read and blend stages to its result word
// throughput: one word per cycle while not stalled; the four texel reads use four replicated banks
// writes fill all four banks at once, after the write delay registers, and give no result
// a stall freezes the whole pipeline and holds input ready low
// reset (rst_ni low, async) clears valids, sizes to zero and filter to bilinear
module wrapped_bilinear_texture_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: texel_index[15:0], texel_red[23:16], texel_green[31:24],
  //        texel_blue[39:32], coord_s[63:40], coord_t[87:64]
  input  logic [87:0] s_axis_tdata,
  // tuser: kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: color_red[15:0], color_green[31:16], color_blue[47:32]
  output logic [47:0] m_axis_tdata
);
  logic [10:0] width_q, height_q;
  logic        filter_q, loaded_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      filter_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (wbts_pkg::cfg_reg_e'(cfg_index_i))
        wbts_pkg::RegWidth:  width_q  <= cfg_data_i;
        wbts_pkg::RegHeight: height_q <= cfg_data_i;
        wbts_pkg::RegFilter: filter_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline enable: advance unless a result waits at a stalled output
  wbts_pkg::stage_ctl_t ctl_out;
  logic en;
  logic in_acc;
  assign en = !(ctl_out.valid && !m_axis_tready);
  assign s_axis_tready = en;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic is_write;
  assign is_write = in_acc && (wbts_pkg::kind_e'(s_axis_tuser) == wbts_pkg::KindWrite);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else if (is_write) begin
      loaded_q <= 1'b1;
    end
  end

  // sample entry control
  logic [10:0] w_eff, h_eff;
  wbts_pkg::stage_ctl_t ctl_in;
  assign w_eff = wbts_pkg::side_of(width_q);
  assign h_eff = wbts_pkg::side_of(height_q);
  assign ctl_in.valid    = in_acc && (wbts_pkg::kind_e'(s_axis_tuser) == wbts_pkg::KindSample);
  assign ctl_in.white    = !loaded_q || w_eff == '0 || h_eff == '0;
  assign ctl_in.bilinear = filter_q;

  wbts_pkg::stage_ctl_t ctl_a;
  logic [15:0] a00, a10, a01, a11, u1, v1;
  logic [3:0]  oob;

  wbts_addr u_addr (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl_in),
    .fs_i(s_axis_tdata[55:40]), .ft_i(s_axis_tdata[79:64]),
    .w_i(w_eff), .h_i(h_eff), .ctl_o(ctl_a),
    .a00_o(a00), .a10_o(a10), .a01_o(a01), .a11_o(a11),
    .oob_o(oob), .u1_o(u1), .v1_o(v1)
  );

  // write delay: a texel write passes wr1_q and wr2_q before it lands in the banks,
  // so samples accepted earlier still read the texels of their own time
  wbts_pkg::texel_t wtex;
  logic             wr1_q, wr2_q;
  logic [15:0]      wa1_q, wa2_q;
  wbts_pkg::texel_t wd1_q, wd2_q;
  logic             bank_we;
  assign wtex = s_axis_tdata[39:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr1_q <= 1'b0;
      wr2_q <= 1'b0;
    end else if (en) begin
      wr1_q <= is_write;
      wr2_q <= wr1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      wa1_q <= s_axis_tdata[15:0];
      wd1_q <= wtex;
      wa2_q <= wa1_q;
      wd2_q <= wd1_q;
    end
  end
  assign bank_we = wr2_q && en;

  // four replicated banks, written together
  wbts_pkg::texel_t rd [4];
  logic [15:0] ra [4];
  assign ra[0] = a00;
  assign ra[1] = a10;
  assign ra[2] = a01;
  assign ra[3] = a11;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    wbts_bank u_bank (
      .clk_i, .we_i(bank_we), .waddr_i(wa2_q), .wdata_i(wd2_q),
      .re_i(en), .raddr_i(ra[b]), .rdata_o(rd[b])
    );
  end

  // read stage control, nearest weights and bounds masking
  wbts_pkg::stage_ctl_t ctl_r_q;
  logic [15:0] u1_r_q, v1_r_q;
  logic [3:0]  oob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_r_q <= '0;
    end else if (en) begin
      ctl_r_q <= ctl_a;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_r_q <= ctl_a.bilinear ? u1 : 16'h0;
      v1_r_q <= ctl_a.bilinear ? v1 : 16'h0;
      oob_q  <= oob;
    end
  end

  wbts_pkg::texel_t tx [4];
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      tx[b] = oob_q[b] ? '0 : rd[b];
    end
  end

  logic [47:0] color;
  wbts_blend u_blend (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl_r_q),
    .t00_i(tx[0]), .t10_i(tx[1]), .t01_i(tx[2]), .t11_i(tx[3]),
    .u1_i(u1_r_q), .v1_i(v1_r_q), .ctl_o(ctl_out), .color_o(color)
  );

  assign m_axis_tvalid = ctl_out.valid;
  assign m_axis_tdata  = color;
endmodule

[hw/rtl/wbts_bank.sv]
// one texel bank: one write port and one registered read port
module wbts_bank (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [wbts_pkg::AddrBits-1:0] waddr_i,
  input  wbts_pkg::texel_t              wdata_i,
  input  logic                          re_i,
  input  logic [wbts_pkg::AddrBits-1:0] raddr_i,
  output wbts_pkg::texel_t              rdata_o
);
  wbts_pkg::texel_t mem [2**wbts_pkg::AddrBits];
  wbts_pkg::texel_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, held while stalled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/wbts_addr.sv]
// address stages: wrap, scale by size, centre, neighbour addresses
module wbts_addr (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  wbts_pkg::stage_ctl_t          ctl_i,
  input  logic [15:0]                   fs_i,
  input  logic [15:0]                   ft_i,
  input  logic [wbts_pkg::SideBits-1:0] w_i,
  input  logic [wbts_pkg::SideBits-1:0] h_i,
  output wbts_pkg::stage_ctl_t          ctl_o,
  output logic [wbts_pkg::AddrBits-1:0] a00_o,
  output logic [wbts_pkg::AddrBits-1:0] a10_o,
  output logic [wbts_pkg::AddrBits-1:0] a01_o,
  output logic [wbts_pkg::AddrBits-1:0] a11_o,
  output logic [3:0]                    oob_o,
  output logic [15:0]                   u1_o,
  output logic [15:0]                   v1_o
);
  // stage 1: scale coordinates by sizes
  wbts_pkg::stage_ctl_t ctl1_q, ctl2_q, ctl3_q;
  logic [26:0] ds_q, dt_q;
  logic [10:0] w1_q, h1_q, w2_q, h2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_q <= 27'(fs_i * w_i);
      dt_q <= 27'(ft_i * h_i);
      w1_q <= w_i;
      h1_q <= h_i;
    end
  end

  // stage 2: centre (bilinear) or plain floor (nearest), neighbour wrap
  logic [27:0] cs, ct;
  logic [10:0] x0_d, y0_d, x1_d, y1_d;
  logic [15:0] u1_d, v1_d;
  logic [10:0] x0_q, y0_q, x1_q, y1_q;
  logic [15:0] u1_q, v1_q, u1_3_q, v1_3_q;

  always_comb begin
    if (ctl1_q.bilinear) begin
      cs = (ds_q < 27'h8000) ? 28'(ds_q) + {1'b0, w1_q, 16'h0} - 28'h8000
                             : 28'(ds_q) - 28'h8000;
      ct = (dt_q < 27'h8000) ? 28'(dt_q) + {1'b0, h1_q, 16'h0} - 28'h8000
                             : 28'(dt_q) - 28'h8000;
    end else begin
      cs = 28'(ds_q);
      ct = 28'(dt_q);
    end
    x0_d = cs[26:16];
    y0_d = ct[26:16];
    u1_d = cs[15:0];
    v1_d = ct[15:0];
    x1_d = (x0_d + 11'd1 == w1_q) ? 11'd0 : x0_d + 11'd1;
    y1_d = (y0_d + 11'd1 == h1_q) ? 11'd0 : y0_d + 11'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl2_q <= ctl1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= x0_d;
      y0_q <= y0_d;
      x1_q <= x1_d;
      y1_q <= y1_d;
      u1_q <= u1_d;
      v1_q <= v1_d;
      w2_q <= w1_q;
      h2_q <= h1_q;
    end
  end

  // stage 3: row-major addresses, one multiply per row
  logic [21:0] r0, r1;
  logic [22:0] s00, s10, s01, s11;
  logic [wbts_pkg::AddrBits-1:0] a00_q, a10_q, a01_q, a11_q;
  logic [3:0] oob_q;

  always_comb begin
    r0  = 22'(y0_q * w2_q);
    r1  = 22'(y1_q * w2_q);
    s00 = 23'(r0) + 23'(x0_q);
    s10 = 23'(r0) + 23'(x1_q);
    s01 = 23'(r1) + 23'(x0_q);
    s11 = 23'(r1) + 23'(x1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl3_q <= ctl2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a00_q  <= s00[15:0];
      a10_q  <= s10[15:0];
      a01_q  <= s01[15:0];
      a11_q  <= s11[15:0];
      oob_q  <= {s11[22:16] != '0, s01[22:16] != '0, s10[22:16] != '0, s00[22:16] != '0};
      u1_3_q <= u1_q;
      v1_3_q <= v1_q;
    end
  end

  assign ctl_o = ctl3_q;
  assign a00_o = a00_q;
  assign a10_o = a10_q;
  assign a01_o = a01_q;
  assign a11_o = a11_q;
  assign oob_o = oob_q;
  assign u1_o  = u1_3_q;
  assign v1_o  = v1_3_q;
endmodule

[hw/rtl/wbts_blend.sv]
// blend stages: weights, weighted texels, channel sums
module wbts_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  wbts_pkg::stage_ctl_t ctl_i,
  input  wbts_pkg::texel_t     t00_i,
  input  wbts_pkg::texel_t     t10_i,
  input  wbts_pkg::texel_t     t01_i,
  input  wbts_pkg::texel_t     t11_i,
  input  logic [15:0]          u1_i,
  input  logic [15:0]          v1_i,
  output wbts_pkg::stage_ctl_t ctl_o,
  output logic [47:0]          color_o
);
  // stage a: four corner weights, 33 bits each
  wbts_pkg::stage_ctl_t ctla_q, ctlb_q, ctlc_q;
  logic [16:0] u0, v0;
  logic [32:0] w00_q, w10_q, w01_q, w11_q;
  wbts_pkg::texel_t t00_q, t10_q, t01_q, t11_q;

  assign u0 = 17'h10000 - 17'(u1_i);
  assign v0 = 17'h10000 - 17'(v1_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctla_q <= '0;
      ctlb_q <= '0;
      ctlc_q <= '0;
    end else if (en_i) begin
      ctla_q <= ctl_i;
      ctlb_q <= ctla_q;
      ctlc_q <= ctlb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w00_q <= 33'(u0 * v0);
      w10_q <= 33'(17'(u1_i) * v0);
      w01_q <= 33'(u0 * 17'(v1_i));
      w11_q <= 33'(17'(u1_i) * 17'(v1_i));
      t00_q <= t00_i;
      t10_q <= t10_i;
      t01_q <= t01_i;
      t11_q <= t11_i;
    end
  end

  // stage b: weighted texels per channel
  logic [40:0] p_q [3][4];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        p_q[c][0] <= 41'(w00_q * t00_q[8*c +: 8]);
        p_q[c][1] <= 41'(w10_q * t10_q[8*c +: 8]);
        p_q[c][2] <= 41'(w01_q * t01_q[8*c +: 8]);
        p_q[c][3] <= 41'(w11_q * t11_q[8*c +: 8]);
      end
    end
  end

  // stage c: sum and scale to 8.8
  logic [47:0] color_q;
  logic [42:0] sum [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = 43'(p_q[c][0]) + 43'(p_q[c][1]) + 43'(p_q[c][2]) + 43'(p_q[c][3]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        if (ctlb_q.white) begin
          color_q[16*c +: 16] <= 16'hFF00;
        end else begin
          color_q[16*c +: 16] <= sum[c][39:24];
        end
      end
    end
  end

  assign ctl_o   = ctlc_q;
  assign color_o = color_q;
endmodule

[hw/rtl/wbts_checker.sv]
// port-level checker for the texture sampler, bound to the top level
`include "assert_macros.svh"
module wbts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        cfg_ready_o
);
  // stalled result holds its word
  `ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // input is refused only behind a stalled result
  `ASSERT_IMP(a_rdy, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // red and green colour channels never exceed 0xff00
  `ASSERT_IMP(a_max, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tdata[15:0] <= 16'hFF00 && m_axis_tdata[31:16] <= 16'hFF00)
  // configuration always taken
  `ASSERT_IMP(a_cfg, clk_i, rst_ni, 1'b1, cfg_ready_o)
endmodule

bind wrapped_bilinear_texture_sampler wbts_checker u_chk (.*);

[verif/sampler_checker.sv]
// checker for the texture sampler: watches the channels, predicts and compares colours
module sampler_checker
  import wbts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } colour_t;

  // texel word: red in the low byte, blue in the high byte
  logic [23:0]  texels [65536];
  bit           loaded_q;
  logic [10:0]  width_q;
  logic [10:0]  height_q;
  logic         bilinear_q;
  colour_t      colours_due[$];

  assign pending_o = colours_due.size();

  function automatic longint unsigned texel_byte(input longint unsigned addr, input int ch);
    if (addr >= 65536) return 0;
    return texels[addr][8*ch +: 8];
  endfunction

  // half-texel centred position: integer part and fraction
  function automatic void centre_pos(input longint unsigned frac, input longint unsigned size,
                                     output longint unsigned ip, output longint unsigned fp);
    longint unsigned d;
    d = frac * size;
    if (d < 64'h8000) d = d + (size << FracBits) - 64'h8000;
    else d = d - 64'h8000;
    ip = d >> FracBits;
    fp = d & 64'hFFFF;
  endfunction

  function automatic colour_t sample_colour(input logic [23:0] cs, input logic [23:0] ct);
    longint unsigned w, h, fs, ft, x0, y0, x1, y1, u0, u1, v0, v1, sum;
    longint unsigned a00, a10, a01, a11;
    logic [15:0] ch_val [3];
    colour_t c;
    w  = (width_q > 11'd1024) ? 1024 : width_q;
    h  = (height_q > 11'd1024) ? 1024 : height_q;
    fs = cs[15:0];
    ft = ct[15:0];
    if (!loaded_q || w == 0 || h == 0) begin
      c.red = 16'hFF00; c.green = 16'hFF00; c.blue = 16'hFF00;
      return c;
    end
    if (!bilinear_q) begin
      a00 = ((ft * h) >> FracBits) * w + ((fs * w) >> FracBits);
      for (int ch = 0; ch < 3; ch++) ch_val[ch] = 16'(texel_byte(a00, ch) << 8);
    end else begin
      centre_pos(fs, w, x0, u1);
      centre_pos(ft, h, y0, v1);
      x1 = (x0 + 1) % w;
      y1 = (y0 + 1) % h;
      u0 = 65536 - u1;
      v0 = 65536 - v1;
      a00 = y0 * w + x0;
      a10 = y0 * w + x1;
      a01 = y1 * w + x0;
      a11 = y1 * w + x1;
      for (int ch = 0; ch < 3; ch++) begin
        sum = u0 * v0 * texel_byte(a00, ch) + u1 * v0 * texel_byte(a10, ch)
            + u1 * v1 * texel_byte(a11, ch) + u0 * v1 * texel_byte(a01, ch);
        ch_val[ch] = 16'(sum >> (2 * FracBits - 8));
      end
    end
    c.red = ch_val[0]; c.green = ch_val[1]; c.blue = ch_val[2];
    return c;
  endfunction

  // register writes, texel writes, sample prediction and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    colour_t want;
    colour_t got;
    if (!rst_ni) begin
      loaded_q     <= 1'b0;
      width_q      <= '0;
      height_q     <= '0;
      bilinear_q   <= 1'b1;
      fail_count_o <= 0;
      colours_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegWidth:  width_q    <= cfg_data_i;
          RegHeight: height_q   <= cfg_data_i;
          RegFilter: bilinear_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (kind_e'(s_axis_tuser) == KindWrite) begin
          texels[s_axis_tdata[15:0]] = s_axis_tdata[39:16];
          loaded_q <= 1'b1;
        end else begin
          colours_due.push_back(sample_colour(s_axis_tdata[63:40], s_axis_tdata[87:64]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (colours_due.size() == 0) begin
          $display("%0t: unexpected colour word %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = colours_due.pop_front();
          if (want != got) begin
            if (want.red != got.red)
              $display("%0t: red expected %h actual %h", $time, want.red, got.red);
            if (want.green != got.green)
              $display("%0t: green expected %h actual %h", $time, want.green, got.green);
            if (want.blue != got.blue)
              $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[verif/tb_top.sv]
// testbench top: stimulus, stall patterns and verdict for the texture sampler
module tb_top;
  import wbts_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;
  int          filled = 0;
  int          stall_mode = 0;

  wrapped_bilinear_texture_sampler u_top (.*);

  sampler_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("wrapped_bilinear_texture_sampler verification failed");
      $finish;
    end
  end

  // receiver stalls in a randomly chosen pattern
  always @(posedge clk_i) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // send one word, in bursts with random gaps
  task automatic send_word(input kind_e kind, input logic [87:0] data);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic write_texel(input logic [15:0] idx, input logic [23:0] rgb);
    send_word(KindWrite, {48'($urandom), rgb, idx});
  endtask

  task automatic sample_at(input logic [23:0] cs, input logic [23:0] ct);
    send_word(KindSample, {ct, cs, 40'({$urandom, $urandom})});
  endtask

  // make sure every texel a sample can reach has been written
  task automatic fill_to(input int n);
    while (filled < n && filled < 65536) begin
      write_texel(16'(filled), 24'($urandom));
      filled++;
    end
  endtask

  // register write, only once the pipeline has drained
  task automatic write_reg(input cfg_reg_e idx, input logic [10:0] val);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_texture(input logic [10:0] w, input logic [10:0] h, input logic bil);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegFilter, 11'(bil));
  endtask

  logic [23:0] edge_coords [8] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                                   24'h008000, 24'h00FFFF, 24'h000001, 24'h3F4000};

  initial begin
    int w, h, side_w, side_h;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing loaded and zero sizes give white
    sample_at(24'h001234, 24'h00ABCD);
    set_texture(11'd4, 11'd4, 1'b1);
    sample_at(24'h004000, 24'h00C000);
    write_texel(16'hFFFF, 24'hFFFFFF);
    write_reg(RegWidth, 11'd0);
    sample_at(24'h000000, 24'h000000);
    set_texture(11'd4, 11'd0, 1'b1);
    sample_at(24'h000000, 24'h000000);

    // small texture, both filters, coordinate extremes
    write_reg(RegHeight, 11'd4);
    fill_to(16);
    for (int i = 0; i < 8; i++) sample_at(edge_coords[i], edge_coords[7 - i]);
    write_reg(RegFilter, 11'd0);
    for (int i = 0; i < 8; i++) sample_at(edge_coords[i], edge_coords[(i + 3) % 8]);

    // oversized sides clamp to the largest size
    set_texture(11'h7FF, 11'd1, 1'b1);
    fill_to(1024);
    for (int i = 0; i < 4; i++) sample_at(edge_coords[i], 24'($urandom));
    set_texture(11'd1, 11'h7FF, 1'b0);
    for (int i = 0; i < 4; i++) sample_at(24'($urandom), edge_coords[i + 4]);

    // full-size texture, reads past the end of the store come back as zero
    set_texture(11'd1024, 11'd1024, 1'b0);
    for (int i = 0; i < 4; i++) sample_at(24'($urandom), 24'($urandom_range(16'h1000, 16'hFFFF)));
    write_reg(RegFilter, 11'd1);
    for (int i = 0; i < 4; i++) sample_at(24'($urandom), 24'($urandom_range(16'h1100, 16'hFFFF)));
    write_reg(RegSpare, 11'h555);

    // random phases: new sizes and filter, then mixed samples and writes
    for (int p = 0; p < 16; p++) begin
      case ($urandom_range(0, 7))
        0: begin w = 0; h = $urandom_range(0, 40); end
        1: begin w = $urandom_range(1, 2047); h = 1; end
        2: begin w = 1; h = $urandom_range(1, 2047); end
        default: begin w = $urandom_range(1, 64); h = $urandom_range(1, 16); end
      endcase
      side_w = (w > 1024) ? 1024 : w;
      side_h = (h > 1024) ? 1024 : h;
      set_texture(11'(w), 11'(h), 1'($urandom));
      fill_to(side_w * side_h);
      for (int i = 0; i < 37; i++) begin
        if ($urandom_range(0, 4) != 0)
          sample_at(24'($urandom), 24'($urandom));
        else if ($urandom_range(0, 3) == 0)
          write_texel(16'($urandom), 24'($urandom));
        else if (filled > 0)
          write_texel(16'($urandom_range(0, filled - 1)), 24'($urandom));
        else
          write_texel(16'hFFFF, 24'($urandom));
      end
    end

    // drain and verdict
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("wrapped_bilinear_texture_sampler verification clean");
    end else begin
      $display("wrapped_bilinear_texture_sampler verification failed");
    end
    $finish;
  end

endmodule
